/* hdl/eqvr_pkg.sv */
// package for the euler quaternion vector rotate unit
// holds formats, the cordic angle table and gain; no dependencies
package eqvr_pkg;

  localparam int AngleBits = 16;
  localparam int CoordBits = 32;
  localparam int TrigFrac  = 16;
  localparam int CordicSteps = 31;
  localparam int CordicW = 34;
  localparam int PhaseW = 34;
  localparam int TrigW = TrigFrac + 2;
  localparam int TW = 36;
  localparam logic signed [CordicW-1:0] CordicGain = CordicW'(652032874);

  function automatic logic signed [PhaseW-1:0] atan_turn(input int i);
    logic [31:0] t;
    begin
      unique case (i)
        0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
        3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
        9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
        27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
        30: t = 32'h00000001;
        default: t = 32'h0;
      endcase
      atan_turn = PhaseW'(t);
    end
  endfunction

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [PhaseW-1:0]  z;
  } cordic_t;

  // x in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic signed [CoordBits-1:0] z;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } vec_t;

endpackage

/* hdl/euler_quaternion_vector_rotate_unit.sv */
// top level of the euler quaternion vector rotate unit
// depends on eqvr_pkg
// Fully pipelined point rotator: one transfer in and one transfer out per
// cycle while the output is not stalled. There are 41 register stages
// (input phase load, 31 cordic iterations, eight stages of trig rounding,
// quaternion and rotation products, and the output register). A stall at
// the output freezes the whole pipeline and drops in_tready; one output
// register holds the finished result.
module euler_quaternion_vector_rotate_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], roll[111:96], pitch[127:112], yaw[143:128]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rot_x[31:0], rot_y[63:32], rot_z[95:64]
  output logic [95:0]  out_tdata
);
  import eqvr_pkg::*;

  localparam int NS = CordicSteps + 10;
  logic [NS-1:0] v_r;
  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // cordic stages, three angles in parallel
  cordic_t cr_r [3][CordicSteps+1];
  vec_t    pv_r [CordicSteps+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cr_r[a][0].x <= CordicGain;
        cr_r[a][0].y <= '0;
        cr_r[a][0].z <= {{(PhaseW-AngleBits-(31-AngleBits)){in_tdata[96+16*a+AngleBits-1]}},
                         in_tdata[96+16*a +: AngleBits], {(31-AngleBits){1'b0}}};
        for (int i = 0; i < CordicSteps; i++) begin
          if (!cr_r[a][i].z[PhaseW-1]) begin
            cr_r[a][i+1].x <= cr_r[a][i].x - (cr_r[a][i].y >>> i);
            cr_r[a][i+1].y <= cr_r[a][i].y + (cr_r[a][i].x >>> i);
            cr_r[a][i+1].z <= cr_r[a][i].z - atan_turn(i);
          end else begin
            cr_r[a][i+1].x <= cr_r[a][i].x + (cr_r[a][i].y >>> i);
            cr_r[a][i+1].y <= cr_r[a][i].y - (cr_r[a][i].x >>> i);
            cr_r[a][i+1].z <= cr_r[a][i].z + atan_turn(i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pv_r[0] <= in_tdata[95:0];
      for (int i = 0; i < CordicSteps; i++) pv_r[i+1] <= pv_r[i];
    end
  end

  function automatic logic signed [TrigW-1:0] trig_rnd(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] s;
    begin
      s = (v + CordicW'(1 << (29 - TrigFrac))) >>> (30 - TrigFrac);
      trig_rnd = TrigW'(s);
    end
  endfunction

  function automatic logic signed [TW-1:0] rq(input logic signed [71:0] v);
    logic signed [71:0] s;
    begin
      s = (v + 72'(1 << (TrigFrac - 1))) >>> TrigFrac;
      rq = TW'(s);
    end
  endfunction

  // stage a: trig rounding
  logic signed [TrigW-1:0] cr_a_r, sr_a_r, cp_a_r, sp_a_r, cy_a_r, sy_a_r;
  vec_t pa_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cr_a_r <= trig_rnd(cr_r[0][CordicSteps].x); sr_a_r <= trig_rnd(cr_r[0][CordicSteps].y);
      cp_a_r <= trig_rnd(cr_r[1][CordicSteps].x); sp_a_r <= trig_rnd(cr_r[1][CordicSteps].y);
      cy_a_r <= trig_rnd(cr_r[2][CordicSteps].x); sy_a_r <= trig_rnd(cr_r[2][CordicSteps].y);
      pa_r <= pv_r[CordicSteps];
    end
  end

  // stage b: A B C D
  logic signed [TrigW-1:0] qa_b_r, qb_b_r, qc_b_r, qd_b_r, cr_b_r, sr_b_r;
  vec_t pb_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      qa_b_r <= TrigW'(rq(72'(cy_a_r * cp_a_r)));
      qb_b_r <= TrigW'(rq(72'(sy_a_r * sp_a_r)));
      qc_b_r <= TrigW'(rq(72'(cy_a_r * sp_a_r)));
      qd_b_r <= TrigW'(rq(72'(sy_a_r * cp_a_r)));
      cr_b_r <= cr_a_r; sr_b_r <= sr_a_r; pb_r <= pa_r;
    end
  end

  // stage c: products for w, u
  logic signed [2*TrigW-1:0] m_c_r [8];
  vec_t pc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_c_r[0] <= qa_b_r * cr_b_r; m_c_r[1] <= qb_b_r * sr_b_r;
      m_c_r[2] <= qa_b_r * sr_b_r; m_c_r[3] <= qb_b_r * cr_b_r;
      m_c_r[4] <= qc_b_r * cr_b_r; m_c_r[5] <= qd_b_r * sr_b_r;
      m_c_r[6] <= qd_b_r * cr_b_r; m_c_r[7] <= qc_b_r * sr_b_r;
      pc_r <= pb_r;
    end
  end

  // stage d: w, u rounding
  logic signed [TrigW-1:0] w_d_r, ux_d_r, uy_d_r, uz_d_r;
  vec_t pd_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      w_d_r  <= TrigW'(rq(72'(m_c_r[0]) + 72'(m_c_r[1])));
      ux_d_r <= TrigW'(rq(72'(m_c_r[2]) - 72'(m_c_r[3])));
      uy_d_r <= TrigW'(rq(72'(m_c_r[4]) + 72'(m_c_r[5])));
      uz_d_r <= TrigW'(rq(72'(m_c_r[6]) - 72'(m_c_r[7])));
      pd_r <= pc_r;
    end
  end

  // stage e: u x v products
  logic signed [TrigW+CoordBits-1:0] n_e_r [6];
  logic signed [TrigW-1:0] w_e_r, ux_e_r, uy_e_r, uz_e_r;
  vec_t pe_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      n_e_r[0] <= uy_d_r * pd_r.z; n_e_r[1] <= uz_d_r * pd_r.y;
      n_e_r[2] <= uz_d_r * pd_r.x; n_e_r[3] <= ux_d_r * pd_r.z;
      n_e_r[4] <= ux_d_r * pd_r.y; n_e_r[5] <= uy_d_r * pd_r.x;
      w_e_r <= w_d_r; ux_e_r <= ux_d_r; uy_e_r <= uy_d_r; uz_e_r <= uz_d_r; pe_r <= pd_r;
    end
  end

  // stage f: t
  logic signed [TW-1:0] tx_f_r, ty_f_r, tz_f_r;
  logic signed [TrigW-1:0] w_f_r, ux_f_r, uy_f_r, uz_f_r;
  vec_t pf_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      tx_f_r <= rq((72'(n_e_r[0]) - 72'(n_e_r[1])) <<< 1);
      ty_f_r <= rq((72'(n_e_r[2]) - 72'(n_e_r[3])) <<< 1);
      tz_f_r <= rq((72'(n_e_r[4]) - 72'(n_e_r[5])) <<< 1);
      w_f_r <= w_e_r; ux_f_r <= ux_e_r; uy_f_r <= uy_e_r; uz_f_r <= uz_e_r; pf_r <= pe_r;
    end
  end

  // stage g: w*t and u x t products
  logic signed [TrigW+TW-1:0] g_g_r [9];
  vec_t pg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      g_g_r[0] <= w_f_r * tx_f_r; g_g_r[1] <= uy_f_r * tz_f_r; g_g_r[2] <= uz_f_r * ty_f_r;
      g_g_r[3] <= w_f_r * ty_f_r; g_g_r[4] <= uz_f_r * tx_f_r; g_g_r[5] <= ux_f_r * tz_f_r;
      g_g_r[6] <= w_f_r * tz_f_r; g_g_r[7] <= ux_f_r * ty_f_r; g_g_r[8] <= uy_f_r * tx_f_r;
      pg_r <= pf_r;
    end
  end

  // stage h: rounded correction
  logic signed [TW-1:0] dx_h_r, dy_h_r, dz_h_r;
  vec_t ph_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_h_r <= rq(72'(g_g_r[0]) + 72'(g_g_r[1]) - 72'(g_g_r[2]));
      dy_h_r <= rq(72'(g_g_r[3]) + 72'(g_g_r[4]) - 72'(g_g_r[5]));
      dz_h_r <= rq(72'(g_g_r[6]) + 72'(g_g_r[7]) - 72'(g_g_r[8]));
      ph_r <= pg_r;
    end
  end

  function automatic logic [CoordBits-1:0] sat_add(input logic signed [CoordBits-1:0] v,
                                                    input logic signed [TW-1:0] d);
    logic signed [TW:0] s;
    begin
      s = (TW+1)'(v) + (TW+1)'(d);
      if (s > (TW+1)'(33'sh0_7FFF_FFFF)) sat_add = 32'h7FFF_FFFF;
      else if (s < -(TW+1)'(33'sh0_8000_0000)) sat_add = 32'h8000_0000;
      else sat_add = s[CoordBits-1:0];
    end
  endfunction

  // stage i: add and saturate into output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {sat_add(ph_r.z, dz_h_r), sat_add(ph_r.y, dy_h_r),
                    sat_add(ph_r.x, dx_h_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end
  assign out_tvalid = v_r[NS-1];

endmodule
